// ===== design/ww_pkg.sv =====
// ----------------------------------------------------------------------------
// ww_pkg: shared types and constants for the Wireworld generation step
// Cell codes, request and result records, and the next-state rule.
// ----------------------------------------------------------------------------
package ww_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int GW_BITS       = 11;

  typedef logic [GW_BITS-1:0] gw_t;
  typedef logic [1:0]         cell_t;
  typedef logic [17:0]        win_t;

  localparam gw_t GW_RESET = 11'd1024;

  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_HEAD  = 2'd1;
  localparam cell_t CELL_TAIL  = 2'd2;
  localparam cell_t CELL_COND  = 2'd3;

  // Control for the cell that sits in the read-modify-write stage.
  typedef struct packed {
    logic  vld;
    logic  emit;
    logic  last;
    logic  fend;
    cell_t cell_val;
  } ww_req_t;

  typedef struct packed {
    cell_t next_state;
    logic  row_end;
    logic  frame_end_out;
  } ww_res_t;

  // Window: newest column in bits 5:0, oldest in 17:12; bottom cell lowest
  // within a column. The centre cell therefore lies at bits 9:8.
  function automatic cell_t ww_evolve(win_t win);
    cell_t       centre;
    cell_t       ev;
    logic [3:0]  heads;
    centre = win[9:8];
    heads  = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4 && win[2*i +: 2] == CELL_HEAD) begin
        heads = heads + 4'd1;
      end
    end
    unique case (centre)
      CELL_EMPTY: ev = CELL_EMPTY;
      CELL_HEAD:  ev = CELL_TAIL;
      CELL_TAIL:  ev = CELL_COND;
      CELL_COND:  ev = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD : CELL_COND;
      default:    ev = CELL_EMPTY;
    endcase
    return ev;
  endfunction

endpackage

// ===== design/ww_ifs.sv =====
// ----------------------------------------------------------------------------
// ww_ifs: channel interfaces
// Cell input, result output and grid width configuration channels.
// ----------------------------------------------------------------------------
interface ww_in_if import ww_pkg::*; ();
  logic  valid;
  logic  ready;
  cell_t cell_state;
  logic  frame_end;
  modport source (output valid, cell_state, frame_end, input ready);
  modport sink   (input valid, cell_state, frame_end, output ready);
endinterface

interface ww_out_if import ww_pkg::*; ();
  logic  valid;
  logic  ready;
  cell_t next_state;
  logic  row_end;
  logic  frame_end_out;
  modport source (output valid, next_state, row_end, frame_end_out, input ready);
  modport sink   (input valid, next_state, row_end, frame_end_out, output ready);
endinterface

interface ww_cfg_if import ww_pkg::*; ();
  logic valid;
  logic ready;
  gw_t  grid_width;
  modport source (output valid, grid_width, input ready);
  modport sink   (input valid, grid_width, output ready);
endinterface

// ===== design/ww_ram.sv =====
// ----------------------------------------------------------------------------
// ww_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ww_ram #(
  parameter int W     = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ww_scan.sv =====
// ----------------------------------------------------------------------------
// ww_scan: raster position tracking
// Keeps the column and row counts, issues the row store read address and
// registers the request for the read-modify-write stage.
// ----------------------------------------------------------------------------
module ww_scan import ww_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  cell_t                        cell_in,
  input  logic                         fend,
  input  logic [$clog2(MAX_WIDTH)-1:0] lastcol,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output ww_req_t                      req,
  output logic [$clog2(MAX_WIDTH)-1:0] col
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] col_r, cur_col;
  logic [1:0]    rows_r, rows_nxt;
  logic          last, emit;
  ww_req_t       req_r, req_nxt;

  always_comb begin
    // A count past the last column (width lowered mid-row) ends the row.
    cur_col = (cnt_r > lastcol) ? lastcol : cnt_r;
    last    = (cur_col == lastcol);
    emit    = (rows_r == 2'd2) && (cur_col >= CW'(2));
    cnt_nxt  = cnt_r;
    rows_nxt = rows_r;
    if (acc) begin
      priority if (fend) begin
        cnt_nxt  = '0;
        rows_nxt = '0;
      end else if (last) begin
        cnt_nxt  = '0;
        if (rows_r != 2'd2) begin
          rows_nxt = rows_r + 2'd1;
        end
      end else begin
        cnt_nxt = cur_col + CW'(1);
      end
    end
    req_nxt = '{vld: acc, emit: emit, last: last, fend: fend, cell_val: cell_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rows_r <= '0;
      req_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      rows_r <= rows_nxt;
      req_r  <= req_nxt;
    end
    if (acc) begin
      col_r <= cur_col;
    end
  end

  assign rd_addr = cur_col;
  assign req     = req_r;
  assign col     = col_r;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    req_r.vld |-> col_r <= lastcol)
    else $error("request column beyond the last column");

endmodule

// ===== design/ww_core.sv =====
// ----------------------------------------------------------------------------
// ww_core: read-modify-write stage
// Merges the row store entry with the new cell, shifts the 3x3 window,
// writes the shifted column back and evaluates the centre cell.
// ----------------------------------------------------------------------------
module ww_core import ww_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  ww_req_t                      req,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  input  logic [3:0]                   rd_data,
  output logic                         we,
  output logic [$clog2(MAX_WIDTH)-1:0] waddr,
  output logic [3:0]                   wdata,
  output logic                         push,
  output ww_res_t                      res
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic       fwd_r;
  logic [3:0] fwd_data_r;
  logic [3:0] entry;
  cell_t      top, mid;
  win_t       win_r, win_nxt, win_cur;

  always_comb begin
    // A read issued while the same entry is being written sees stale data.
    entry   = fwd_r ? fwd_data_r : rd_data;
    top     = entry[3:2];
    mid     = entry[1:0];
    win_cur = {win_r[11:0], top, mid, req.cell_val};
    we      = req.vld;
    waddr   = col;
    wdata   = {mid, req.cell_val};
    push    = req.vld && req.emit;
    res     = '{next_state: ww_evolve(win_cur), row_end: req.last,
                frame_end_out: req.fend};
    win_nxt = win_r;
    if (req.vld) begin
      win_nxt = req.fend ? '0 : win_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      fwd_r <= 1'b0;
    end else begin
      win_r <= win_nxt;
      fwd_r <= acc && req.vld && (rd_addr == col);
    end
    fwd_data_r <= wdata;
  end

  a_emit_col: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> col >= CW'(2))
    else $error("result emitted for a border column");

endmodule

// ===== design/ww_outq.sv =====
// ----------------------------------------------------------------------------
// ww_outq: result queue
// Three-entry queue that decouples the result channel from the pipeline.
// ----------------------------------------------------------------------------
module ww_outq import ww_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  ww_res_t push_data,
  input  logic    pend,
  output logic    space,
  output logic    out_valid,
  output ww_res_t out_data,
  input  logic    out_ready
);

  ww_res_t    q_r [3];
  logic [1:0] wp_r, rp_r, cnt_r;
  logic [1:0] wp_nxt, rp_nxt, cnt_nxt;
  logic       pop;

  always_comb begin
    pop       = (cnt_r != 2'd0) && out_ready;
    out_valid = (cnt_r != 2'd0);
    out_data  = q_r[rp_r];
    // Room must remain for the request still in the pipeline stage.
    space     = ({1'b0, cnt_r} + {2'b00, pend}) < 3'd3;
    wp_nxt    = push ? ((wp_r == 2'd2) ? 2'd0 : wp_r + 2'd1) : wp_r;
    rp_nxt    = pop  ? ((rp_r == 2'd2) ? 2'd0 : rp_r + 2'd1) : rp_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r != 2'd3)
    else $error("result queue overflow");

endmodule

// ===== design/wireworld_generation_step.sv =====
// ----------------------------------------------------------------------------
// wireworld_generation_step: streaming Wireworld generation step
// An accepted cell is registered as a request; its result then enters the
// result queue, which offers it. One cell is taken per clock while the queue
// has room, with one row memory read and write-back each. Reset clears the
// counters, window and queue and sets grid_width to 1024; row memory stays.
// ----------------------------------------------------------------------------
module wireworld_generation_step import ww_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ww_in_if.sink     in_ch,
  ww_out_if.source  out_ch,
  ww_cfg_if.sink    cfg_ch
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WEW = (CW + 1 > GW_BITS) ? CW + 1 : GW_BITS;

  gw_t           gw_r;
  logic [WEW-1:0] gw_ext;
  logic [CW-1:0] lastcol;
  logic          acc, space, push;
  logic [CW-1:0] rd_addr, col, waddr;
  logic          we;
  logic [3:0]    wdata, rd_data;
  ww_req_t       req;
  ww_res_t       res, out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GW_RESET;
    end else if (cfg_ch.valid) begin
      gw_r <= cfg_ch.grid_width;
    end
  end

  always_comb begin
    gw_ext = WEW'(gw_r);
    priority if (gw_ext < WEW'(3)) begin
      lastcol = CW'(2);
    end else if (gw_ext > WEW'(MAX_WIDTH)) begin
      lastcol = CW'(MAX_WIDTH - 1);
    end else begin
      lastcol = CW'(gw_ext - WEW'(1));
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = space;
  assign acc          = in_ch.valid && space;

  ww_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .cell_in (in_ch.cell_state),
    .fend    (in_ch.frame_end),
    .lastcol (lastcol),
    .rd_addr (rd_addr),
    .req     (req),
    .col     (col)
  );

  // Each entry holds the cell two rows back (upper) and one row back (lower).
  ww_ram #(.W(4), .DEPTH(MAX_WIDTH)) u_rows (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (acc),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ww_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rd_addr (rd_addr),
    .req     (req),
    .col     (col),
    .rd_data (rd_data),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .push    (push),
    .res     (res)
  );

  ww_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .pend      (req.vld),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_data  (out_data),
    .out_ready (out_ch.ready)
  );

  assign out_ch.next_state    = out_data.next_state;
  assign out_ch.row_end       = out_data.row_end;
  assign out_ch.frame_end_out = out_data.frame_end_out;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> req.vld)
    else $error("accepted request did not reach the update stage");

endmodule

// ===== bench/tb_wireworld_generation_step.sv =====
// ----------------------------------------------------------------------------
// tb_wireworld_generation_step: self-checking bench for the Wireworld step
// Streams grids of cells through the block with random stalls on both sides,
// predicts every next-generation result with a line-buffered model of its own
// and checks each result request field by field, in order.
// ----------------------------------------------------------------------------
module tb_wireworld_generation_step;
  timeunit 1ns;
  timeprecision 1ps;
  import ww_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 400;
  localparam int CALM_ITEMS    = 80;
  localparam int DIR_ROWS      = 24;
  localparam int WIDE_CUT      = 60;

  typedef struct packed {
    cell_t   cell_val;
    logic    fend;
    bit      typed;
    ww_res_t res;
  } stim_row_t;

  localparam ww_res_t NO_RES = '0;

  // Width 3 throughout. A five-row grid with a head, a conductor next to one
  // head and a tail at the centres; a frame ending in column 0 and another in
  // column 1; then a frame of only two rows, which yields nothing.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{CELL_COND,  1'b0, 1'b0, NO_RES},
    '{CELL_COND,  1'b0, 1'b0, NO_RES},
    '{CELL_COND,  1'b0, 1'b0, NO_RES},
    '{CELL_COND,  1'b0, 1'b0, NO_RES},
    '{CELL_HEAD,  1'b0, 1'b0, NO_RES},
    '{CELL_COND,  1'b0, 1'b0, NO_RES},
    '{CELL_COND,  1'b0, 1'b0, NO_RES},
    '{CELL_COND,  1'b0, 1'b0, NO_RES},
    '{CELL_COND,  1'b0, 1'b1, '{CELL_TAIL, 1'b1, 1'b0}},
    '{CELL_TAIL,  1'b0, 1'b0, NO_RES},
    '{CELL_TAIL,  1'b0, 1'b0, NO_RES},
    '{CELL_TAIL,  1'b0, 1'b0, NO_RES},
    '{CELL_HEAD,  1'b0, 1'b0, NO_RES},
    '{CELL_EMPTY, 1'b0, 1'b0, NO_RES},
    '{CELL_HEAD,  1'b1, 1'b1, '{CELL_COND, 1'b1, 1'b1}},
    '{CELL_COND,  1'b1, 1'b0, NO_RES},
    '{CELL_HEAD,  1'b0, 1'b0, NO_RES},
    '{CELL_TAIL,  1'b1, 1'b0, NO_RES},
    '{CELL_HEAD,  1'b0, 1'b0, NO_RES},
    '{CELL_HEAD,  1'b0, 1'b0, NO_RES},
    '{CELL_HEAD,  1'b0, 1'b0, NO_RES},
    '{CELL_COND,  1'b0, 1'b0, NO_RES},
    '{CELL_COND,  1'b0, 1'b0, NO_RES},
    '{CELL_COND,  1'b1, 1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;

  ww_in_if  in_if ();
  ww_out_if out_if ();
  ww_cfg_if cfg_if ();

  wireworld_generation_step u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Bench copy of the line stores, window and counters.
  cell_t       upper_row  [MAX_WIDTH_DEF];
  cell_t       middle_row [MAX_WIDTH_DEF];
  win_t        window_now;
  int unsigned col_count;
  int unsigned rows_done;
  gw_t         width_reg;

  ww_res_t     pending_gens [$];
  int          errors;
  int unsigned cells_sent;
  bit          calm;
  bit          hold_req;
  int          rx_stall_pct;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int unsigned eff_width(gw_t w);
    if (w < 3) return 3;
    if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return 32'(w);
  endfunction

  function automatic cell_t next_gen(win_t w);
    cell_t centre;
    int    heads;
    centre = w[9:8];
    heads  = 0;
    if (centre == CELL_EMPTY) return CELL_EMPTY;
    if (centre == CELL_HEAD) return CELL_TAIL;
    if (centre == CELL_TAIL) return CELL_COND;
    for (int cl = 0; cl < 3; cl++) begin
      for (int rw = 0; rw < 3; rw++) begin
        if (!(cl == 1 && rw == 1) && w[(2 - cl) * 6 + (2 - rw) * 2 +: 2] == CELL_HEAD) begin
          heads++;
        end
      end
    end
    return (heads == 1 || heads == 2) ? CELL_HEAD : CELL_COND;
  endfunction

  // Moves one cell through the bench's line stores; returns 1 when the block
  // should emit a result for it.
  function automatic bit advance_grid(input cell_t c, input logic fend, output ww_res_t r);
    int unsigned w;
    int unsigned col;
    logic        last;
    cell_t       top;
    cell_t       mid;
    bit          emit;
    w    = eff_width(width_reg);
    col  = (col_count > w - 1) ? w - 1 : col_count;
    last = (col == w - 1);
    top  = upper_row[col];
    mid  = middle_row[col];
    upper_row[col]  = mid;
    middle_row[col] = c;
    window_now = {window_now[11:0], top, mid, c};
    emit = (rows_done >= 2 && col >= 2);
    r.next_state    = next_gen(window_now);
    r.row_end       = last;
    r.frame_end_out = fend;
    if (fend) begin
      col_count  = 0;
      rows_done  = 0;
      window_now = '0;
    end else if (last) begin
      col_count = 0;
      if (rows_done < 2) rows_done++;
    end else begin
      col_count = col + 1;
    end
    return emit;
  endfunction

  function automatic cell_t rand_cell();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 25) return CELL_EMPTY;
    if (p < 45) return CELL_HEAD;
    if (p < 60) return CELL_TAIL;
    return CELL_COND;
  endfunction

  task automatic send_cell(input cell_t c, input logic fend, input bit typed,
                           input ww_res_t typed_res);
    ww_res_t r;
    in_if.valid      <= 1'b1;
    in_if.cell_state <= c;
    in_if.frame_end  <= fend;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (advance_grid(c, fend, r)) begin
      pending_gens.push_back(typed ? typed_res : r);
    end
    cells_sent++;
  endtask

  task automatic maybe_pause(input int gap_pct);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Holds the input off until every expected result has been taken, then
  // allows for a silent cell that the block may still be working on.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_gens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input gw_t v);
    cfg_if.valid      <= 1'b1;
    cfg_if.grid_width <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    width_reg = v;
  endtask

  // Sends one grid at the current width. A non-zero cut ends the frame early;
  // a non-zero shrink_at narrows the grid part-way through, once idle.
  task automatic run_frame(input int unsigned rows, input bit tidy, input int unsigned cut,
                           input int unsigned shrink_at, input gw_t shrink_to,
                           input int gap_pct);
    int unsigned w;
    int unsigned total;
    int unsigned r;
    int unsigned k;
    cell_t       c;
    w     = eff_width(width_reg);
    total = rows * w;
    if (cut != 0 && cut < total) total = cut;
    for (int unsigned n = 0; n < total; n++) begin
      if (shrink_at != 0 && n == shrink_at) begin
        settle();
        write_width(shrink_to);
      end
      r = n / w;
      k = n % w;
      if (tidy && (r == 0 || r == rows - 1 || k == 0 || k == w - 1)) c = CELL_EMPTY;
      else c = rand_cell();
      send_cell(c, n == total - 1, 1'b0, NO_RES);
      maybe_pause(gap_pct);
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    ww_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_gens.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got next_state %0d row_end %0d frame_end_out %0d",
                 $time, out_if.next_state, out_if.row_end, out_if.frame_end_out);
      end else begin
        want = pending_gens.pop_front();
        if (out_if.next_state !== want.next_state) begin
          errors++;
          $display("%0t: next_state expected %0d got %0d", $time, want.next_state,
                   out_if.next_state);
        end
        if (out_if.row_end !== want.row_end) begin
          errors++;
          $display("%0t: row_end expected %0d got %0d", $time, want.row_end, out_if.row_end);
        end
        if (out_if.frame_end_out !== want.frame_end_out) begin
          errors++;
          $display("%0t: frame_end_out expected %0d got %0d", $time, want.frame_end_out,
                   out_if.frame_end_out);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_wireworld_generation_step NOT OK");
    $finish;
  end

  initial begin
    int unsigned start_sent;
    int unsigned rows;
    int unsigned w;
    int unsigned cut;
    int unsigned shrink_at;
    int unsigned frame_no;
    int          kind;
    int          gap_pct;
    gw_t         shrink_to;

    errors       = 0;
    cells_sent   = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    rx_stall_pct = 0;
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      upper_row[i]  = CELL_EMPTY;
      middle_row[i] = CELL_EMPTY;
    end
    window_now = '0;
    col_count  = 0;
    rows_done  = 0;
    width_reg  = GW_RESET;

    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.cell_state  <= CELL_EMPTY;
    in_if.frame_end   <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.grid_width <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The width left by reset is the widest grid; a frame cut short in its
    // first row yields nothing.
    run_frame(3, 1'b0, WIDE_CUT, 0, '0, 0);
    settle();

    // Directed cells on the narrowest grid; zero is raised to three.
    write_width('0);
    foreach (dir_rows[i]) begin
      send_cell(dir_rows[i].cell_val, dir_rows[i].fend, dir_rows[i].typed, dir_rows[i].res);
    end
    settle();

    // All ones in the width register is clamped to the widest grid.
    write_width(11'h7FF);
    rx_stall_pct = 20;
    run_frame(3, 1'b0, WIDE_CUT, 0, '0, 15);
    settle();

    start_sent = cells_sent;
    frame_no   = 0;
    while (cells_sent - start_sent < RANDOM_ITEMS) begin
      if (cells_sent - start_sent > RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!calm && $urandom_range(0, 1) == 0) begin
        settle();
        if ($urandom_range(0, 4) == 0) write_width(gw_t'($urandom_range(0, 2)));
        else write_width(gw_t'($urandom_range(3, 12)));
      end
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 10;
        default: rx_stall_pct = 35;
      endcase
      w         = eff_width(width_reg);
      rows      = $urandom_range(3, 6);
      kind      = $urandom_range(0, 9);
      // Early on, the result side holds off long enough to back up the input;
      // a full six-row frame makes sure there are enough results to do so.
      if (frame_no == 3) begin
        hold_req = 1'b1;
        gap_pct  = 0;
        rows     = 6;
        kind     = 0;
      end
      cut       = 0;
      shrink_at = 0;
      shrink_to = '0;
      if (kind >= 8) cut = $urandom_range(1, rows * w);
      if (kind == 7) begin
        shrink_at = $urandom_range(1, rows * w - 1);
        shrink_to = gw_t'($urandom_range(0, w - 1));
      end
      run_frame(rows, kind < 7, cut, shrink_at, shrink_to, gap_pct);
      frame_no++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_wireworld_generation_step OK");
    end else begin
      $display("tb_wireworld_generation_step NOT OK");
    end
    $finish;
  end

endmodule
